// File: hdl/cgts_pkg.sv
package cgts_pkg;

  localparam int MAX_TYPES   = 16;
  localparam int TYPE_W      = 4;
  localparam int MAX_TOKENS  = 65536;
  localparam int TOK_W       = 16;
  localparam int MAX_GENES   = 1024;
  localparam int GENE_W      = 10;
  localparam int MAX_SAMPLES = 64;
  localparam int SAMP_W      = 6;

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

  // fixed point widths of the weight path
  localparam int Q_W   = 30;
  localparam int NUM_W = 34;
  localparam int DEN_W = 41;
  localparam int FAC_W = 34;
  localparam int W_W   = 48;
  localparam int SUM_W = 52;
  localparam logic [Q_W-1:0] Q_MAX = 30'h3FFF_FFFF;

  localparam int NT_W    = 5;
  localparam int ALPHA_W = 24;
  localparam int BT_W    = 40;
  localparam int BETA_W  = 24;
  localparam int RND_W   = 32;

  localparam logic [1:0] KIND_INIT     = 2'd0;
  localparam logic [1:0] KIND_RESAMPLE = 2'd1;
  localparam logic [1:0] KIND_READ     = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TYPES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_TOTAL = 2'd2;

  typedef logic [MAX_TYPES-1:0][CNT_W-1:0] row_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TOK_W-1:0]  token;
    logic [GENE_W-1:0] gene;
    logic [SAMP_W-1:0] sample_idx;
    logic [BETA_W-1:0] gene_beta;
    logic [RND_W-1:0]  random_word;
    logic [TYPE_W-1:0] read_type;
  } item_t;

  typedef struct packed {
    logic [TYPE_W-1:0] chosen_type;
    logic [CNT_W-1:0]  gene_type_count;
    logic [CNT_W-1:0]  sample_type_count;
    logic [CNT_W-1:0]  type_total;
  } res_t;

  typedef struct packed {
    logic clr;
    logic latch;
    logic rd;
    logic load;
    logic pick;
    logic remove;
    logic div_start;
    logic mul1;
    logic mul2;
    logic thr1;
    logic thr2;
    logic scan;
    logic add;
    logic wb;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       div_done;
    logic       last;
    logic       hit;
    logic [1:0] kind;
  } stat_t;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    cnt_inc = (c < CNT_MAX) ? c + 1'b1 : c;
  endfunction

  function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
    cnt_dec = (c != '0) ? c - 1'b1 : c;
  endfunction

endpackage

// File: hdl/cgts_if.sv
interface cgts_in_if;
  import cgts_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [TOK_W-1:0]  token;
  logic [GENE_W-1:0] gene;
  logic [SAMP_W-1:0] sample_idx;
  logic [BETA_W-1:0] gene_beta;
  logic [RND_W-1:0]  random_word;
  logic [TYPE_W-1:0] read_type;
  modport source(output valid, kind, token, gene, sample_idx, gene_beta, random_word,
                 read_type, input ready);
  modport sink(input valid, kind, token, gene, sample_idx, gene_beta, random_word,
               read_type, output ready);
endinterface

interface cgts_out_if;
  import cgts_pkg::*;
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] chosen_type;
  logic [CNT_W-1:0]  gene_type_count;
  logic [CNT_W-1:0]  sample_type_count;
  logic [CNT_W-1:0]  type_total;
  modport source(output valid, chosen_type, gene_type_count, sample_type_count, type_total,
                 input ready);
  modport sink(input valid, chosen_type, gene_type_count, sample_type_count, type_total,
               output ready);
endinterface

// File: hdl/cgts_div.sv
module cgts_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cgts_pkg::NUM_W-1:0] num,
  input  logic [cgts_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [cgts_pkg::Q_W-1:0]   q
);
  import cgts_pkg::*;

  localparam int DVD_W = NUM_W + 16;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   lo_r, lo_nxt;
  logic [Q_W-1:0]   quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;

  logic [DVD_W-1:0] dvd;
  logic [DEN_W:0]   r1, r1s, r2, r2s;
  logic             b1, b2;

  always_comb begin
    dvd = {num, 16'h0};
    r1  = {rem_r, lo_r[Q_W-1]};
    b1  = r1 >= {1'b0, den_r};
    r1s = b1 ? r1 - {1'b0, den_r} : r1;
    r2  = {r1s[DEN_W-1:0], lo_r[Q_W-2]};
    b2  = r2 >= {1'b0, den_r};
    r2s = b2 ? r2 - {1'b0, den_r} : r2;

    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      den_nxt = den;
      quo_nxt = '0;
      if (num == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if ({21'h0, dvd} >= {den, 30'h0}) begin
        // quotient would not fit, also covers a zero divisor
        quo_nxt  = Q_MAX;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = DEN_W'(dvd[DVD_W-1:Q_W]);
        lo_nxt   = dvd[Q_W-1:0];
        cnt_nxt  = 4'd14;
        busy_nxt = 1'b1;
        done_nxt = 1'b0;
      end
    end else if (busy_r) begin
      // two quotient bits per cycle
      rem_nxt = r2s[DEN_W-1:0];
      lo_nxt  = {lo_r[Q_W-3:0], 2'b00};
      quo_nxt = {quo_r[Q_W-3:0], b1, b2};
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign q    = quo_r;

endmodule

// File: hdl/cgts_dp.sv
module cgts_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cgts_pkg::cmd_t              cmd,
  output cgts_pkg::stat_t             stat,
  input  cgts_pkg::item_t             item,
  input  logic [cgts_pkg::NT_W-1:0]    act_t,
  input  logic [cgts_pkg::ALPHA_W-1:0] alpha,
  input  logic [cgts_pkg::BT_W-1:0]    beta_total,
  output cgts_pkg::res_t              res
);
  import cgts_pkg::*;

  item_t item_r;

  logic [MAX_TYPES*CNT_W-1:0] gene_mem [MAX_GENES];
  logic [MAX_TYPES*CNT_W-1:0] samp_mem [MAX_SAMPLES];
  logic [TYPE_W-1:0]          asg_mem  [MAX_TOKENS];

  row_t              gene_rd_r, samp_rd_r;
  logic [TYPE_W-1:0] asg_rd_r;
  logic [GENE_W-1:0] clr_cnt_r;

  row_t                          gene_row_r, samp_row_r;
  logic [MAX_TYPES-1:0][CNT_W-1:0] tot_r;
  logic [TYPE_W-1:0]             old_r, t_r, j_r;

  logic [Q_W+17-1:0]             p_lo_r;
  logic [MAX_TYPES-1:0][W_W-1:0] w_r;
  logic [SUM_W-1:0]              sum_r, thr_r, cum_r;
  logic [RND_W+26-1:0]           p1_r;

  logic [TYPE_W-1:0] idx;
  logic [CNT_W-1:0]  gc, sc, tc;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [FAC_W-1:0]  fac;
  logic [Q_W-1:0]    q;
  logic              div_done;
  logic [RND_W+NT_W-1:0] pick_prod;
  logic [63:0]       wprod;
  logic [W_W-1:0]    w_new;
  logic [RND_W+SUM_W-1:0] tprod;
  logic [SUM_W-1:0]  cum_nxt;
  logic              last;
  logic              is_read;
  logic              rt_ok;

  assign is_read = (item_r.kind == KIND_READ);

  always_comb begin
    if (cmd.remove)        idx = old_r;
    else if (cmd.add)      idx = t_r;
    else if (cmd.out_load) idx = is_read ? item_r.read_type : t_r;
    else                   idx = j_r;
  end

  assign gc  = gene_row_r[idx];
  assign sc  = samp_row_r[idx];
  assign tc  = tot_r[idx];
  assign num = NUM_W'({gc, 16'h0}) + NUM_W'(item_r.gene_beta);
  assign den = DEN_W'({tc, 16'h0}) + DEN_W'(beta_total);
  assign fac = FAC_W'({sc, 16'h0}) + FAC_W'(alpha);

  cgts_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (num),
    .den  (den),
    .done (div_done),
    .q    (q)
  );

  assign pick_prod = (RND_W+NT_W)'(item_r.random_word) * (RND_W+NT_W)'(act_t);
  // high half of q times the sample factor, added to the registered low half
  assign wprod = 64'(p_lo_r) + (64'(q * fac[FAC_W-1:17]) << 17);
  assign w_new = wprod[63:16];
  assign tprod = (RND_W+SUM_W)'(p1_r)
               + ((RND_W+SUM_W)'(item_r.random_word * sum_r[SUM_W-1:26]) << 26);
  assign cum_nxt = cum_r + SUM_W'(w_r[j_r]);
  assign last = (j_r == TYPE_W'(act_t - NT_W'(1)));

  assign stat.clr_done = (clr_cnt_r == GENE_W'(MAX_GENES - 1));
  assign stat.div_done = div_done;
  assign stat.last     = last;
  assign stat.hit      = (cum_nxt >= thr_r) || last;
  assign stat.kind     = item_r.kind;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.clr) gene_mem[clr_cnt_r] <= '0;
    else if (cmd.wb) gene_mem[item_r.gene] <= gene_row_r;
    if (cmd.rd) gene_rd_r <= gene_mem[item_r.gene];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) samp_mem[clr_cnt_r[SAMP_W-1:0]] <= '0;
    else if (cmd.wb) samp_mem[item_r.sample_idx] <= samp_row_r;
    if (cmd.rd) samp_rd_r <= samp_mem[item_r.sample_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) asg_mem[item_r.token] <= t_r;
    if (cmd.rd) asg_rd_r <= asg_mem[item_r.token];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      tot_r     <= '0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + GENE_W'(1);
      if (cmd.remove) tot_r[idx] <= cnt_dec(tc);
      else if (cmd.add) tot_r[idx] <= cnt_inc(tc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= item;
    if (cmd.load) begin
      gene_row_r <= gene_rd_r;
      samp_row_r <= samp_rd_r;
      old_r      <= asg_rd_r;
    end else if (cmd.remove) begin
      gene_row_r[idx] <= cnt_dec(gc);
      samp_row_r[idx] <= cnt_dec(sc);
    end else if (cmd.add) begin
      gene_row_r[idx] <= cnt_inc(gc);
      samp_row_r[idx] <= cnt_inc(sc);
    end
    if (cmd.pick) t_r <= pick_prod[RND_W+TYPE_W-1:RND_W];
    else if (cmd.scan) t_r <= j_r;
    if (cmd.remove || cmd.thr2) j_r <= '0;
    else if (cmd.mul2 || cmd.scan) j_r <= j_r + TYPE_W'(1);
    if (cmd.remove) sum_r <= '0;
    else if (cmd.mul2) sum_r <= sum_r + SUM_W'(w_new);
    if (cmd.mul1) p_lo_r <= q * fac[16:0];
    if (cmd.mul2) w_r[j_r] <= w_new;
    if (cmd.thr1) p1_r <= item_r.random_word * sum_r[25:0];
    if (cmd.thr2) begin
      thr_r <= tprod[RND_W+SUM_W-1:32];
      cum_r <= '0;
    end else if (cmd.scan) begin
      cum_r <= cum_nxt;
    end
  end

  assign rt_ok = ({1'b0, item_r.read_type} < (TYPE_W+1)'(MAX_TYPES));

  always_comb begin
    res.chosen_type       = is_read ? '0 : t_r;
    res.gene_type_count   = gc;
    res.sample_type_count = sc;
    res.type_total        = tc;
    if (is_read && !rt_ok) begin
      res.gene_type_count   = '0;
      res.sample_type_count = '0;
      res.type_total        = '0;
    end
  end

endmodule

// File: hdl/cgts_ctrl.sv
module cgts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_kind,
  input  logic            out_free,
  input  cgts_pkg::stat_t stat,
  output cgts_pkg::cmd_t  cmd,
  output logic            in_ready
);
  import cgts_pkg::*;

  typedef enum logic [15:0] {
    S_CLEAR  = 16'h0001,
    S_IDLE   = 16'h0002,
    S_RD     = 16'h0004,
    S_LOAD   = 16'h0008,
    S_INIT   = 16'h0010,
    S_REMOVE = 16'h0020,
    S_DIVST  = 16'h0040,
    S_DIV    = 16'h0080,
    S_MUL1   = 16'h0100,
    S_MUL2   = 16'h0200,
    S_THR1   = 16'h0400,
    S_THR2   = 16'h0800,
    S_SCAN   = 16'h1000,
    S_ADD    = 16'h2000,
    S_WB     = 16'h4000,
    S_OUT    = 16'h8000
  } st_t;

  st_t st_r, st_nxt;

  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_ready = 1'b0;
    case (st_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid && in_kind != KIND_NONE) st_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        st_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        case (stat.kind)
          KIND_READ:     st_nxt = S_OUT;
          KIND_INIT:     st_nxt = S_INIT;
          KIND_RESAMPLE: st_nxt = S_REMOVE;
          default:       st_nxt = S_IDLE;
        endcase
      end
      S_INIT: begin
        cmd.pick = 1'b1;
        st_nxt   = S_ADD;
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        st_nxt     = S_DIVST;
      end
      S_DIVST: begin
        cmd.div_start = 1'b1;
        st_nxt        = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) st_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        st_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        st_nxt   = stat.last ? S_THR1 : S_DIVST;
      end
      S_THR1: begin
        cmd.thr1 = 1'b1;
        st_nxt   = S_THR2;
      end
      S_THR2: begin
        cmd.thr2 = 1'b1;
        st_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) st_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        st_nxt  = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_CLEAR;
    else        st_r <= st_nxt;
  end

endmodule

// File: hdl/collapsed_gibbs_topic_sampler_unit.sv
// collapsed gibbs topic sampler: keeps gene-by-type, sample-by-type and per-type counts
// and assigns each token a latent type. one item is worked at a time. after reset the
// count memories are swept to zero, one gene row a cycle, during which no beat is taken
// (config writes still land). a read beat goes from acceptance through the memory read
// and the row load to the result register; an init beat also picks a type, adds its
// counts and writes them back. a resample beat removes the old type, then each active
// type needs one pass through the shared divider, which retires two quotient bits a
// cycle, plus a split multiply for the weight; a type whose quotient is zero or
// saturates skips the divide loop. then the threshold multiply and a one-type-per-cycle
// scan of the cumulative weights. a finished result waits in the output register while
// the next beat is taken. config (num_types, alpha, beta_total) is written on the cfg
// port with index 0, 1, 2 and must only change while idle
module collapsed_gibbs_topic_sampler_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  cgts_in_if.sink                              in_ch,
  cgts_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [cgts_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [cgts_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import cgts_pkg::*;

  // config registers
  logic [NT_W-1:0]    num_types_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [BT_W-1:0]    beta_total_r;
  logic [NT_W-1:0]    act_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_types_r  <= NT_W'(16);
      alpha_r      <= ALPHA_W'(65536);
      beta_total_r <= BT_W'(65536);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NUM_TYPES:  num_types_r  <= cfg_wdata[NT_W-1:0];
        CFG_ALPHA:      alpha_r      <= cfg_wdata[ALPHA_W-1:0];
        CFG_BETA_TOTAL: beta_total_r <= cfg_wdata[BT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one type, anything past the limit as the limit
  always_comb begin
    if (num_types_r == '0) act_t = NT_W'(1);
    else if (num_types_r > NT_W'(MAX_TYPES)) act_t = NT_W'(MAX_TYPES);
    else act_t = num_types_r;
  end

  item_t item;
  assign item.kind        = in_ch.kind;
  assign item.token       = in_ch.token;
  assign item.gene        = in_ch.gene;
  assign item.sample_idx  = in_ch.sample_idx;
  assign item.gene_beta   = in_ch.gene_beta;
  assign item.random_word = in_ch.random_word;
  assign item.read_type   = in_ch.read_type;

  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  logic  in_ready;

  // output register: one result beat waits here
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;
  logic out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_res_r <= res;
  end

  cgts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_kind (in_ch.kind),
    .out_free(out_free),
    .stat    (stat),
    .cmd     (cmd),
    .in_ready(in_ready)
  );

  cgts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .act_t     (act_t),
    .alpha     (alpha_r),
    .beta_total(beta_total_r),
    .res       (res)
  );

  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.chosen_type       = out_res_r.chosen_type;
  assign out_ch.gene_type_count   = out_res_r.gene_type_count;
  assign out_ch.sample_type_count = out_res_r.sample_type_count;
  assign out_ch.type_total        = out_res_r.type_total;

endmodule
